[sv/oocp_pkg.sv]
package oocp_pkg;

	localparam logic [15:0] MIN_CURRENT    = 16'd5;
	localparam logic [15:0] PWM_READ_DELAY = 16'd100;
	localparam logic [15:0] FAULT_RAW      = 16'd30000;

	localparam logic [1:0] STATE_OFF   = 2'd0;
	localparam logic [1:0] STATE_ON    = 2'd1;
	localparam logic [1:0] STATE_OC    = 2'd2;
	localparam logic [1:0] STATE_FAULT = 2'd3;

	localparam logic [1:0] RETRY_NONE  = 2'd0;
	localparam logic [1:0] RETRY_COUNT = 2'd1;

	localparam logic [2:0] REG_ENABLED       = 3'd0;
	localparam logic [2:0] REG_CURRENT_LIMIT = 3'd1;
	localparam logic [2:0] REG_INRUSH_LIMIT  = 3'd2;
	localparam logic [2:0] REG_INRUSH_TIME   = 3'd3;
	localparam logic [2:0] REG_RETRY_MODE    = 3'd4;
	localparam logic [2:0] REG_RETRY_LIMIT   = 3'd5;
	localparam logic [2:0] REG_RETRY_DELAY   = 3'd6;
	localparam logic [2:0] REG_CURRENT_GAIN  = 3'd7;

	typedef enum logic [3:0] {
		MODE_OFF   = 4'b0001,
		MODE_ON    = 4'b0010,
		MODE_OC    = 4'b0100,
		MODE_FAULT = 4'b1000
	} mode_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		c = STATE_OFF;
		unique case (m)
			MODE_OFF:   c = STATE_OFF;
			MODE_ON:    c = STATE_ON;
			MODE_OC:    c = STATE_OC;
			MODE_FAULT: c = STATE_FAULT;
			default:    c = STATE_OFF;
		endcase
		return c;
	endfunction

endpackage

[sv/output_overcurrent_protector.sv]
// Path: an accepted input word passes through the input register, then the
// result register, to become its result word.
// Throughput: one word per cycle while result_stall is low; the multiply, limit
// compares and state update all sit between the input register and the result register.
// Reset: asynchronous, active low; channel off, counters and times cleared,
// configuration back to its defaults.
module output_overcurrent_protector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [15:0] sense_raw,
	input  logic        request_on,
	input  logic [31:0] now_ms,
	input  logic        pwm_active,
	input  logic [15:0] pwm_count,
	input  logic [15:0] pwm_compare,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  channel_state,
	output logic [15:0] current_tenths,
	output logic [7:0]  overcurrent_events
);
	import oocp_pkg::*;

	logic        enabled_q;
	logic [11:0] current_limit_q;
	logic [11:0] inrush_limit_q;
	logic [14:0] inrush_time_q;
	logic [1:0]  retry_mode_q;
	logic [3:0]  retry_limit_q;
	logic [14:0] retry_delay_q;
	logic [19:0] current_gain_q;

	mode_t       mode_q;
	logic [7:0]  event_count_q;
	logic [31:0] turn_on_time_q;
	logic [31:0] trip_time_q;
	logic [15:0] held_sample_q;

	logic        valid_s1;
	logic [15:0] raw_s1;
	logic        req_s1;
	logic [31:0] now_s1;
	logic        pwm_s1;
	logic [15:0] cnt_s1;
	logic [15:0] cmp_s1;

	logic        advance;
	logic        step;

	logic        window;
	logic        use_held;
	logic [15:0] sample;
	logic [35:0] product;
	logic [19:0] scaled;
	logic [15:0] cur;
	logic        inrush;
	logic        trip;
	logic [31:0] since_on;
	logic [31:0] since_trip;
	mode_t       mode_a;
	mode_t       mode_d;
	logic [7:0]  count_d;
	logic [31:0] turn_on_d;
	logic [31:0] trip_time_d;
	logic [15:0] held_d;
	logic [15:0] cur_d;

	assign cfg_ready  = 1'b1;
	assign advance    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			current_limit_q <= 12'd20;
			inrush_limit_q  <= 12'd30;
			inrush_time_q   <= 15'd1000;
			retry_mode_q    <= RETRY_NONE;
			retry_limit_q   <= 4'd0;
			retry_delay_q   <= 15'd1000;
			current_gain_q  <= 20'd9990;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLED:       enabled_q       <= cfg_data[0];
				REG_CURRENT_LIMIT: current_limit_q <= cfg_data[11:0];
				REG_INRUSH_LIMIT:  inrush_limit_q  <= cfg_data[11:0];
				REG_INRUSH_TIME:   inrush_time_q   <= cfg_data[14:0];
				REG_RETRY_MODE:    retry_mode_q    <= cfg_data[1:0];
				REG_RETRY_LIMIT:   retry_limit_q   <= cfg_data[3:0];
				REG_RETRY_DELAY:   retry_delay_q   <= cfg_data[14:0];
				REG_CURRENT_GAIN:  current_gain_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			raw_s1 <= sense_raw;
			req_s1 <= request_on;
			now_s1 <= now_ms;
			pwm_s1 <= pwm_active;
			cnt_s1 <= pwm_count;
			cmp_s1 <= pwm_compare;
		end
	end

	always_comb begin
		window   = (cmp_s1 > PWM_READ_DELAY) && (cnt_s1 > PWM_READ_DELAY) && (cnt_s1 < cmp_s1);
		use_held = pwm_s1 && (mode_q == MODE_ON) && !window;
		sample   = use_held ? held_sample_q : raw_s1;
		held_d   = (pwm_s1 && (mode_q == MODE_ON) && window) ? raw_s1 : held_sample_q;

		product = {20'd0, sample} * {16'd0, current_gain_q};
		scaled  = product[35:16];
		cur     = (scaled[19:16] != 4'd0) ? 16'hFFFF : scaled[15:0];
		if (cur <= MIN_CURRENT) begin
			cur = 16'd0;
		end

		mode_a     = (sample > FAULT_RAW) ? MODE_FAULT : mode_q;
		since_on   = now_s1 - turn_on_time_q;
		since_trip = now_s1 - trip_time_q;
		inrush     = since_on < {17'd0, inrush_time_q};
		trip       = inrush ? (cur > {4'd0, inrush_limit_q}) : (cur > {4'd0, current_limit_q});

		mode_d      = mode_a;
		count_d     = event_count_q;
		turn_on_d   = turn_on_time_q;
		trip_time_d = trip_time_q;
		cur_d       = cur;

		unique case (mode_a)
			MODE_OFF: begin
				count_d = 8'd0;
				if (req_s1) begin
					turn_on_d = now_s1;
					mode_d    = MODE_ON;
				end
			end
			MODE_ON: begin
				if (!req_s1) begin
					mode_d = MODE_OFF;
				end
				if (trip) begin
					trip_time_d = now_s1;
					if (event_count_q != 8'hFF) begin
						count_d = event_count_q + 8'd1;
					end
					mode_d = MODE_OC;
				end
			end
			MODE_OC: begin
				if (retry_mode_q == RETRY_NONE) begin
					mode_d = MODE_FAULT;
				end
				if (retry_mode_q == RETRY_COUNT && event_count_q >= {4'd0, retry_limit_q}) begin
					mode_d = MODE_FAULT;
				end
				if (since_trip > {17'd0, retry_delay_q}) begin
					turn_on_d = now_s1;
					mode_d    = MODE_ON;
				end
				if (!req_s1) begin
					mode_d = MODE_OFF;
				end
			end
			MODE_FAULT: ;
			default: ;
		endcase

		if (!enabled_q) begin
			mode_d      = MODE_OFF;
			count_d     = 8'd0;
			turn_on_d   = turn_on_time_q;
			trip_time_d = trip_time_q;
			held_d      = held_sample_q;
			cur_d       = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_OFF;
			event_count_q  <= 8'd0;
			turn_on_time_q <= 32'd0;
			trip_time_q    <= 32'd0;
			held_sample_q  <= 16'd0;
			result_valid   <= 1'b0;
		end else begin
			if (advance) begin
				result_valid <= valid_s1;
			end
			if (step) begin
				mode_q         <= mode_d;
				event_count_q  <= count_d;
				turn_on_time_q <= turn_on_d;
				trip_time_q    <= trip_time_d;
				held_sample_q  <= held_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (step) begin
			channel_state      <= mode_code(mode_d);
			current_tenths     <= cur_d;
			overcurrent_events <= count_d;
		end
	end

endmodule

[sv/oocp_checker.sv]
module oocp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  channel_state,
	input logic [15:0] current_tenths,
	input logic [7:0]  overcurrent_events
);
	import oocp_pkg::*;

	logic res_take;
	assign res_take = result_valid && !result_stall;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (current_tenths == 16'd0) || (current_tenths > MIN_CURRENT))
		else $error("current below floor not zeroed");

	a_oc_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && channel_state == STATE_OC |-> overcurrent_events != 8'd0)
		else $error("overcurrent state with zero event count");

	a_fault_latch: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && channel_state == STATE_FAULT ##1 res_take |->
			channel_state != STATE_ON && channel_state != STATE_OC)
		else $error("fault left without passing through off");

endmodule

bind output_overcurrent_protector oocp_checker u_oocp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.result_valid       (result_valid),
	.result_stall       (result_stall),
	.channel_state      (channel_state),
	.current_tenths     (current_tenths),
	.overcurrent_events (overcurrent_events)
);
